// File: rtl/sobel_edge_magnitude_top_macros.svh
// assertion macros used by the checker file
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SEM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sem_pkg.sv
// shared types and constants of the sobel edge block
`timescale 1ns / 1ps
package sem_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int GEOM_W     = 11;
	localparam int SQ_W       = 22;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_THR_EN  = 2'd2,
		REG_THR_LVL = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_GRAD,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_FIN
	} state_t;

	// one window column: top, middle, bottom
	typedef struct packed {
		logic [7:0] t;
		logic [7:0] m;
		logic [7:0] b;
	} col_t;

	// line store control
	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wr_older;
		logic [7:0]        wr_newer;
	} ls_ctrl_t;

endpackage

// File: rtl/sem_if.sv
// stream and configuration interfaces
`timescale 1ns / 1ps
interface sem_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	modport source (output valid, blue, green, red, input ready);
	modport sink (input valid, blue, green, red, output ready);
endinterface

interface sem_edge_if;
	logic       valid;
	logic       ready;
	logic [7:0] edge_value;
	logic [9:0] out_row;
	logic [9:0] out_column;
	logic       frame_done;
	modport source (output valid, edge_value, out_row, out_column, frame_done, input ready);
	modport sink (input valid, edge_value, out_row, out_column, frame_done, output ready);
endinterface

interface sem_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [10:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/sem_line_store.sv
// two line stores with registered reads
`timescale 1ns / 1ps
module sem_line_store (
	input  logic             clk,
	input  sem_pkg::ls_ctrl_t ctrl,
	output logic [7:0]       rd_older,
	output logic [7:0]       rd_newer
);

	logic [7:0] older_mem [sem_pkg::MAX_WIDTH];
	logic [7:0] newer_mem [sem_pkg::MAX_WIDTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			older_mem[ctrl.addr] <= ctrl.wr_older;
			newer_mem[ctrl.addr] <= ctrl.wr_newer;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_older <= older_mem[ctrl.addr];
			rd_newer <= newer_mem[ctrl.addr];
		end
	end

endmodule

// File: rtl/sobel_edge_magnitude_top.sv
// sobel edge magnitude top level
// Usage:
//   pix    : BGR pixels in raster order, transfer on valid and ready.
//   result : edge value with its row and column, frame_done on the last
//            pixel of a frame; transfer on valid and ready.
//   cfg    : register writes (width, height, threshold enable, threshold
//            level), always ready; the user writes only while the block is
//            idle, unenforced. A width or height write restarts the frame.
// Sequence: a pixel is taken in the idle state, then the read state reads
//   and updates the two line stores; each result it causes then passes
//   through the shared gradient and square-root unit (gradient, squaring
//   of x and of y, eight root steps, final rounding). No new pixel is
//   taken until the unit is through with the last one.
// The result sits in an output register, so the next pixel is taken while
//   it waits; when the receiver stalls, further results wait in the unit.
// Reset clears counters, window and configuration registers to their defaults; the line
//   stores need no clearing, as every entry is written before its use.
`timescale 1ns / 1ps
module sobel_edge_magnitude_top (
	input  logic           clk,
	input  logic           arst_n,
	sem_pix_if.sink        pix,
	sem_edge_if.source     result,
	sem_cfg_if.sink        cfg
);

	sem_pkg::state_t state_q, state_d;

	logic [sem_pkg::GEOM_W-1:0] width_q, height_q, eff_w, eff_h;
	logic                       thr_en_q;
	logic [7:0]                 thr_lvl_q;

	logic [9:0]  r_q, c_q, r_s1, c_s1, r_eff, c_eff;
	logic [7:0]  gray_s1;
	logic [7:0]  win_q [9];
	logic [1:0]  slot_q;
	logic signed [10:0] gx_q, gy_q;
	logic [20:0] sqx_q;
	logic [sem_pkg::SQ_W-1:0] s_q;
	logic [7:0]  root_q;
	logic [2:0]  bit_q;

	logic       out_valid_q, frame_done_q;
	logic [7:0] edge_q;
	logic [9:0] row_q, col_q;

	logic accept, out_free, last_row, last_col;
	sem_pkg::ls_ctrl_t ls_ctrl;
	logic [7:0] rd_older, rd_newer;

	// clamped geometry
	always_comb begin
		eff_w = width_q;
		if (width_q < 11'd3) eff_w = 11'd3;
		if (width_q > 11'(sem_pkg::MAX_WIDTH)) eff_w = 11'(sem_pkg::MAX_WIDTH);
		eff_h = height_q;
		if (height_q < 11'd3) eff_h = 11'd3;
		if (height_q > 11'(sem_pkg::MAX_HEIGHT)) eff_h = 11'(sem_pkg::MAX_HEIGHT);
	end

	assign cfg.ready = 1'b1;
	assign pix.ready = (state_q == sem_pkg::ST_IDLE);
	assign accept    = pix.valid && pix.ready;
	assign out_free  = !out_valid_q || result.ready;

	// position of the incoming pixel
	always_comb begin
		r_eff = r_q;
		c_eff = c_q;
		if ({1'b0, r_q} >= eff_h || {1'b0, c_q} >= eff_w) begin
			r_eff = '0;
			c_eff = '0;
		end
	end

	assign last_row = ({1'b0, r_s1} == eff_h - 11'd1);
	assign last_col = ({1'b0, c_s1} == eff_w - 11'd1);

	// configuration registers and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		logic [10:0] c_n, r_n;
		if (!arst_n) begin
			width_q   <= 11'd1024;
			height_q  <= 11'd1024;
			thr_en_q  <= 1'b1;
			thr_lvl_q <= 8'd100;
			r_q       <= '0;
			c_q       <= '0;
		end else begin
			c_n = {1'b0, c_eff} + 11'd1;
			r_n = {1'b0, r_eff} + 11'd1;
			if (accept) begin
				if (c_n >= eff_w) begin
					c_q <= '0;
					r_q <= (r_n >= eff_h) ? 10'd0 : r_n[9:0];
				end else begin
					c_q <= c_n[9:0];
					r_q <= r_eff;
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					sem_pkg::REG_WIDTH: begin
						width_q <= cfg.data;
						r_q <= '0;
						c_q <= '0;
					end
					sem_pkg::REG_HEIGHT: begin
						height_q <= cfg.data;
						r_q <= '0;
						c_q <= '0;
					end
					sem_pkg::REG_THR_EN: thr_en_q <= cfg.data[0];
					sem_pkg::REG_THR_LVL: thr_lvl_q <= cfg.data[7:0];
					default: ;
				endcase
			end
		end
	end

	// line store access
	always_comb begin
		ls_ctrl.rd_en    = accept;
		ls_ctrl.wr_en    = (state_q == sem_pkg::ST_READ);
		ls_ctrl.addr     = (state_q == sem_pkg::ST_READ) ? c_s1 : c_eff;
		ls_ctrl.wr_older = rd_newer;
		ls_ctrl.wr_newer = gray_s1;
	end

	sem_line_store u_ls (
		.clk      (clk),
		.ctrl     (ls_ctrl),
		.rd_older (rd_older),
		.rd_newer (rd_newer)
	);

	// gray conversion and item capture
	always_ff @(posedge clk) begin
		logic [21:0] gsum;
		gsum = 22'd1868 * {14'd0, pix.blue} + 22'd9617 * {14'd0, pix.green}
			+ 22'd4899 * {14'd0, pix.red} + 22'd8192;
		if (accept) begin
			gray_s1 <= gsum[21:14];
			r_s1    <= r_eff;
			c_s1    <= c_eff;
		end
	end

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (state_q == sem_pkg::ST_READ) begin
			for (int i = 0; i < 6; i++) win_q[i] <= win_q[i + 3];
			win_q[6] <= rd_older;
			win_q[7] <= rd_newer;
			win_q[8] <= gray_s1;
		end
	end

	// window columns for the current output slot
	sem_pkg::col_t wcol [3];
	sem_pkg::col_t lc, mc, rc;
	logic [1:0] lsel, msel, rsel;
	logic [10:0] sxr, sxl, syt, syb;
	logic signed [11:0] gx_c, gy_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			wcol[k].t = win_q[3 * k];
			wcol[k].m = win_q[3 * k + 1];
			wcol[k].b = win_q[3 * k + 2];
		end
		lsel = slot_q[1] ? 2'd1 : ((c_s1 == 10'd1) ? 2'd2 : 2'd0);
		msel = slot_q[1] ? 2'd2 : 2'd1;
		rsel = slot_q[1] ? 2'd1 : 2'd2;
		lc = wcol[lsel];
		mc = wcol[msel];
		rc = wcol[rsel];
		// top border mirrors row one
		if (r_s1 == 10'd1) begin
			lc.t = lc.b;
			mc.t = mc.b;
			rc.t = rc.b;
		end
		// bottom border: last row window
		if (slot_q[0]) begin
			lc = '{t: lc.m, m: lc.b, b: lc.m};
			mc = '{t: mc.m, m: mc.b, b: mc.m};
			rc = '{t: rc.m, m: rc.b, b: rc.m};
		end
		sxr  = {3'd0, rc.t} + {2'd0, rc.m, 1'b0} + {3'd0, rc.b};
		sxl  = {3'd0, lc.t} + {2'd0, lc.m, 1'b0} + {3'd0, lc.b};
		syt  = {3'd0, lc.t} + {2'd0, mc.t, 1'b0} + {3'd0, rc.t};
		syb  = {3'd0, lc.b} + {2'd0, mc.b, 1'b0} + {3'd0, rc.b};
		gx_c = $signed({1'b0, sxr}) - $signed({1'b0, sxl});
		gy_c = $signed({1'b0, syt}) - $signed({1'b0, syb});
	end

	// result value
	logic [7:0]  cand;
	logic [15:0] cand_sq, root_sq, thr_sq;
	logic [16:0] root_lim;
	logic [7:0]  value_c;
	logic [9:0]  row_c, col_c;
	logic        done_c;

	always_comb begin
		cand     = root_q | (8'd1 << bit_q);
		cand_sq  = cand * cand;
		root_sq  = root_q * root_q;
		root_lim = {1'b0, root_sq} + {9'd0, root_q};
		thr_sq   = thr_lvl_q * thr_lvl_q;
		if (thr_en_q)
			value_c = (s_q > {6'd0, thr_sq}) ? 8'd255 : 8'd0;
		else if (s_q >= 22'd65281)
			value_c = 8'd255;
		else if (s_q > {5'd0, root_lim})
			value_c = root_q + 8'd1;
		else
			value_c = root_q;
		row_c  = r_s1 - 10'd1 + {9'd0, slot_q[0]};
		col_c  = c_s1 - 10'd1 + {9'd0, slot_q[1]};
		done_c = ({1'b0, row_c} == eff_h - 11'd1) && ({1'b0, col_c} == eff_w - 11'd1);
	end

	// datapath registers of the shared unit
	always_ff @(posedge clk) begin
		case (state_q)
			sem_pkg::ST_GRAD: begin
				gx_q <= gx_c[10:0];
				gy_q <= gy_c[10:0];
			end
			sem_pkg::ST_SQX: sqx_q <= 21'(gx_q * gx_q);
			sem_pkg::ST_SQY: begin
				s_q    <= {1'b0, sqx_q} + 22'(gy_q * gy_q);
				root_q <= '0;
				bit_q  <= 3'd7;
			end
			sem_pkg::ST_ROOT: begin
				if ({6'd0, cand_sq} <= s_q) root_q <= cand;
				bit_q <= bit_q - 3'd1;
			end
			default: ;
		endcase
	end

	// slot sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (state_q == sem_pkg::ST_READ) begin
			slot_q <= 2'd0;
		end else if (state_q == sem_pkg::ST_FIN && out_free) begin
			case (slot_q)
				2'd0: slot_q <= last_row ? 2'd1 : 2'd2;
				2'd1: slot_q <= 2'd2;
				2'd2: slot_q <= 2'd3;
				default: slot_q <= 2'd0;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sem_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sem_pkg::ST_IDLE: if (accept) state_d = sem_pkg::ST_READ;
			sem_pkg::ST_READ:
				state_d = (r_s1 != 10'd0 && c_s1 != 10'd0) ? sem_pkg::ST_GRAD
					: sem_pkg::ST_IDLE;
			sem_pkg::ST_GRAD: state_d = sem_pkg::ST_SQX;
			sem_pkg::ST_SQX:  state_d = sem_pkg::ST_SQY;
			sem_pkg::ST_SQY:  state_d = sem_pkg::ST_ROOT;
			sem_pkg::ST_ROOT: if (bit_q == 3'd0) state_d = sem_pkg::ST_FIN;
			sem_pkg::ST_FIN: begin
				if (out_free) begin
					case (slot_q)
						2'd0: state_d = (last_row || last_col) ? sem_pkg::ST_GRAD
							: sem_pkg::ST_IDLE;
						2'd1: state_d = last_col ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
						2'd2: state_d = last_row ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
						default: state_d = sem_pkg::ST_IDLE;
					endcase
				end
			end
			default: state_d = sem_pkg::ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == sem_pkg::ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sem_pkg::ST_FIN && out_free) begin
			edge_q       <= value_c;
			row_q        <= row_c;
			col_q        <= col_c;
			frame_done_q <= done_c;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.edge_value = edge_q;
	assign result.out_row    = row_q;
	assign result.out_column = col_q;
	assign result.frame_done = frame_done_q;

endmodule

// File: rtl/sem_chk.sv
// port checker for the sobel edge block and its binding
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_top_macros.svh"
module sem_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] edge_value,
	input logic [9:0] out_row,
	input logic [9:0] out_column,
	input logic       frame_done
);

	logic [28:0] payload;

	// whole result payload
	assign payload = {edge_value, out_row, out_column, frame_done};

	// stalled result keeps valid
	`SEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	// stalled result keeps payload
	`SEM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(payload), "result changed")
	// a pixel transfer is followed by the line store update cycle
	`SEM_ASSERT_NEXT(a_in_gap, in_valid && in_ready, !in_ready, "pixel taken during update")
	// frame end lies past the smallest frame
	`SEM_ASSERT_NOW(a_done_pos, out_valid && frame_done, out_row >= 10'd2 && out_column >= 10'd2, "bad frame end")

endmodule

bind sobel_edge_magnitude_top sem_chk u_sem_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pix.valid),
	.in_ready   (pix.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.edge_value (result.edge_value),
	.out_row    (result.out_row),
	.out_column (result.out_column),
	.frame_done (result.frame_done)
);
